/* hdl/bilinear_texture_sampler_unit_macros.svh */
// Assertion macros for the bilinear texture sampler.
// Included by files that check their own logic; needs nothing else.
`ifndef BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BTS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/bts_pkg.sv */
// Shared types, constants and helpers for the bilinear texture sampler.
// No dependencies.
`timescale 1ns / 1ps
package bts_pkg;
  localparam int MAX_DIM     = 256;
  localparam int POS_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = POS_W + 1;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int ADDR_W      = 16;
  localparam int CH_W        = 8;
  localparam int TEXEL_W     = 3 * CH_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = CFG_IDX_W'(1);

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [TEXEL_W-1:0] texel_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    texel_t data;
  } wr_t;

  // zero acts as one, anything above the max acts as the max
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) r = DIM_W'(1);
    else if (d > CFG_DATA_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = DIM_W'(d);
    return r;
  endfunction
endpackage

/* hdl/bts_ram.sv */
// Texel RAM: one write port, two registered read ports.
// Depends on bts_pkg.
`timescale 1ns / 1ps
module bts_ram (
  input  logic            clk,
  input  bts_pkg::wr_t    wr,
  input  bts_pkg::addr_t  rd_addr_a,
  input  bts_pkg::addr_t  rd_addr_b,
  output bts_pkg::texel_t rd_data_a,
  output bts_pkg::texel_t rd_data_b
);
  bts_pkg::texel_t mem [2**bts_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end
endmodule

/* hdl/bilinear_texture_sampler_unit.sv */
// Top level of the bilinear texture sampler with edge-clamped addressing.
// Depends on bts_pkg, bts_ram and the assertion macro header.
//
// channel  | handshake              | word
// ---------+------------------------+------------------------------------------
// input    | start & !busy          | in_command, in_texel_address/value, in_u/v
// result   | out_valid (one cycle)  | out_red, out_green, out_blue, out_no_texture
// config   | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// One word per cycle; busy stays low. Register stages: capture, scale, address,
// RAM read, horizontal blend, vertical blend into the output. Writes and reads
// hit the two RAM copies at the same stage, so in-order items never race.
// Synchronous reset clears control only; RAM contents are undefined until
// written. The receiver cannot stall.
`timescale 1ns / 1ps
`include "bilinear_texture_sampler_unit_macros.svh"
module bilinear_texture_sampler_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [15:0]                       in_texel_address,
  input  logic [31:0]                       in_texel_value,
  input  logic signed [31:0]                in_u_coord,
  input  logic signed [31:0]                in_v_coord,
  output logic                              out_valid,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic                              out_no_texture,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0]    cfg_data
);
  localparam int WB    = bts_pkg::WEIGHT_BITS;
  localparam int FB    = bts_pkg::FRAC_BITS;
  localparam int PW    = bts_pkg::POS_W;
  localparam int DW    = bts_pkg::DIM_W;
  localparam int CW    = bts_pkg::CH_W;
  localparam int TOP_W = CW + WB;
  localparam int SUM_W = CW + 2 * WB + 1;
  localparam logic [WB:0] S_ONE = (WB + 1)'(1) << WB;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (2 * WB - 1);

  logic accept;
  logic smp_acc, wr_acc;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign smp_acc   = accept && in_command == bts_pkg::CMD_SAMPLE;
  assign wr_acc    = accept && in_command == bts_pkg::CMD_WRITE;

  // configuration
  logic [bts_pkg::CFG_DATA_W-1:0] tex_width_r, tex_height_r;
  logic [DW-1:0] w_dim, h_dim;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= bts_pkg::CFG_DATA_W'(256);
      tex_height_r <= bts_pkg::CFG_DATA_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bts_pkg::REG_TEX_WIDTH:  tex_width_r  <= cfg_data;
        bts_pkg::REG_TEX_HEIGHT: tex_height_r <= cfg_data;
        default: ;
      endcase
    end
  end
  assign w_dim = bts_pkg::clamp_dim(tex_width_r);
  assign h_dim = bts_pkg::clamp_dim(tex_height_r);

  // stage 0: capture
  logic             loaded_r;
  logic             s0_smp_r, s0_wr_r, s0_notex_r;
  bts_pkg::addr_t   s0_addr_r;
  bts_pkg::texel_t  s0_data_r;
  logic [FB-1:0]    s0_fu_r, s0_fv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
      s0_smp_r <= 1'b0;
      s0_wr_r  <= 1'b0;
    end else begin
      if (accept && in_command == bts_pkg::CMD_WRITE) loaded_r <= 1'b1;
      s0_smp_r <= accept && in_command == bts_pkg::CMD_SAMPLE;
      s0_wr_r  <= accept && in_command == bts_pkg::CMD_WRITE;
    end
    s0_notex_r <= !loaded_r;
    s0_addr_r  <= in_texel_address[bts_pkg::ADDR_W-1:0];
    s0_data_r  <= in_texel_value[bts_pkg::TEXEL_W-1:0];
    s0_fu_r    <= in_u_coord[FB-1:0];
    s0_fv_r    <= in_v_coord[FB-1:0];
  end

  // stage 1: scale fractions by size - 1
  logic [FB+PW-1:0] scaled_u, scaled_v;
  assign scaled_u = (FB + PW)'(s0_fu_r) * (FB + PW)'(PW'(w_dim - DW'(1)));
  assign scaled_v = (FB + PW)'(s0_fv_r) * (FB + PW)'(PW'(h_dim - DW'(1)));

  logic             s1_smp_r, s1_wr_r, s1_notex_r;
  bts_pkg::addr_t   s1_addr_r;
  bts_pkg::texel_t  s1_data_r;
  logic [PW-1:0]    s1_x0_r, s1_y0_r;
  logic [WB-1:0]    s1_dx_r, s1_dy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_smp_r <= 1'b0;
      s1_wr_r  <= 1'b0;
    end else begin
      s1_smp_r <= s0_smp_r;
      s1_wr_r  <= s0_wr_r;
    end
    s1_notex_r <= s0_notex_r;
    s1_addr_r  <= s0_addr_r;
    s1_data_r  <= s0_data_r;
    s1_x0_r    <= scaled_u[FB +: PW];
    s1_y0_r    <= scaled_v[FB +: PW];
    s1_dx_r    <= scaled_u[FB-1 -: WB];
    s1_dy_r    <= scaled_v[FB-1 -: WB];
  end

  // stage 2: neighbor clamp and row-major indices
  logic [PW-1:0]    x1, y1;
  logic [PW+DW-1:0] base0, base1;
  assign x1 = (DW'(s1_x0_r) + DW'(1) < w_dim) ? s1_x0_r + PW'(1) : PW'(w_dim - DW'(1));
  assign y1 = (DW'(s1_y0_r) + DW'(1) < h_dim) ? s1_y0_r + PW'(1) : PW'(h_dim - DW'(1));
  assign base0 = (PW + DW)'(s1_y0_r) * (PW + DW)'(w_dim);
  assign base1 = (PW + DW)'(y1) * (PW + DW)'(w_dim);

  logic             s2_smp_r, s2_notex_r;
  bts_pkg::wr_t     s2_wr_r;
  bts_pkg::addr_t   s2_i00_r, s2_i10_r, s2_i01_r, s2_i11_r;
  logic [WB-1:0]    s2_dx_r, s2_dy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_smp_r   <= 1'b0;
      s2_wr_r.en <= 1'b0;
    end else begin
      s2_smp_r   <= s1_smp_r;
      s2_wr_r.en <= s1_wr_r;
    end
    s2_wr_r.addr <= s1_addr_r;
    s2_wr_r.data <= s1_data_r;
    s2_notex_r   <= s1_notex_r;
    s2_i00_r <= bts_pkg::ADDR_W'(base0 + (PW + DW)'(s1_x0_r));
    s2_i10_r <= bts_pkg::ADDR_W'(base0 + (PW + DW)'(x1));
    s2_i01_r <= bts_pkg::ADDR_W'(base1 + (PW + DW)'(s1_x0_r));
    s2_i11_r <= bts_pkg::ADDR_W'(base1 + (PW + DW)'(x1));
    s2_dx_r  <= s1_dx_r;
    s2_dy_r  <= s1_dy_r;
  end

  // stage 3: two identical copies give four reads per cycle
  bts_pkg::texel_t c00, c10, c01, c11;
  bts_ram u_ram_upper (
    .clk(clk), .wr(s2_wr_r),
    .rd_addr_a(s2_i00_r), .rd_addr_b(s2_i10_r),
    .rd_data_a(c00), .rd_data_b(c10)
  );
  bts_ram u_ram_lower (
    .clk(clk), .wr(s2_wr_r),
    .rd_addr_a(s2_i01_r), .rd_addr_b(s2_i11_r),
    .rd_data_a(c01), .rd_data_b(c11)
  );

  logic          s3_smp_r, s3_notex_r;
  logic [WB-1:0] s3_dx_r, s3_dy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_smp_r <= 1'b0;
    else        s3_smp_r <= s2_smp_r;
    s3_notex_r <= s2_notex_r;
    s3_dx_r    <= s2_dx_r;
    s3_dy_r    <= s2_dy_r;
  end

  // stage 4: horizontal blend per channel
  logic [WB:0]        wx1, wx0, wy1, wy0;
  logic [TOP_W:0]     top_full [3];
  logic [TOP_W:0]     bot_full [3];
  assign wx1 = (WB + 1)'(s3_dx_r);
  assign wx0 = S_ONE - wx1;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      top_full[ch] = (TOP_W + 1)'(c00[CW*ch +: CW]) * (TOP_W + 1)'(wx0)
                   + (TOP_W + 1)'(c10[CW*ch +: CW]) * (TOP_W + 1)'(wx1);
      bot_full[ch] = (TOP_W + 1)'(c01[CW*ch +: CW]) * (TOP_W + 1)'(wx0)
                   + (TOP_W + 1)'(c11[CW*ch +: CW]) * (TOP_W + 1)'(wx1);
    end
  end

  logic             s4_smp_r, s4_notex_r;
  logic [WB-1:0]    s4_dy_r;
  logic [TOP_W-1:0] s4_top_r [3];
  logic [TOP_W-1:0] s4_bot_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s4_smp_r <= 1'b0;
    else        s4_smp_r <= s3_smp_r;
    s4_notex_r <= s3_notex_r;
    s4_dy_r    <= s3_dy_r;
    for (int ch = 0; ch < 3; ch++) begin
      s4_top_r[ch] <= top_full[ch][TOP_W-1:0];
      s4_bot_r[ch] <= bot_full[ch][TOP_W-1:0];
    end
  end

  // stage 5: vertical blend, round half up
  logic [SUM_W-1:0] vsum [3];
  logic [CW-1:0]    chan [3];
  assign wy1 = (WB + 1)'(s4_dy_r);
  assign wy0 = S_ONE - wy1;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      vsum[ch] = SUM_W'(s4_top_r[ch]) * SUM_W'(wy0)
               + SUM_W'(s4_bot_r[ch]) * SUM_W'(wy1) + HALF;
      chan[ch] = vsum[ch][2*WB +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= s4_smp_r;
    out_no_texture <= s4_notex_r;
    // nothing loaded: magenta
    out_red   <= s4_notex_r ? 8'hFF : chan[2];
    out_green <= s4_notex_r ? 8'h00 : chan[1];
    out_blue  <= s4_notex_r ? 8'hFF : chan[0];
  end

  `BTS_ASSERT_SAME(a_out_from_sample, clk, rst_n, out_valid, $past(smp_acc, 6))
  `BTS_ASSERT_SAME(a_magenta, clk, rst_n, out_valid && out_no_texture, {out_red, out_green, out_blue} == 24'hFF00FF)
  `BTS_ASSERT_SAME(a_write_loaded, clk, rst_n, s2_wr_r.en, loaded_r)
  `BTS_ASSERT_NEXT(a_write_sets_loaded, clk, rst_n, wr_acc, loaded_r)
endmodule
